/* rtl/upd_pkg.sv */
// upd_pkg: shared constants, escape phase type and hex digit helper
// for the URL percent decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam int unsigned NIBBLE_BITS = 4;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_PLUS_AS_SPACE = 3'd0;

	// escape phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// hex digit value; anything that is not a hex digit gives 0
	function automatic logic [NIBBLE_BITS-1:0] hex_value(input logic [7:0] c);
		logic [NIBBLE_BITS-1:0] v;
		begin
			v = '0;
			if (c inside {[8'h30:8'h39]}) begin
				v = c[NIBBLE_BITS-1:0];
			end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
				v = NIBBLE_BITS'(c[2:0] + 3'd1) + NIBBLE_BITS'(8);
			end
			return v;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/url_percent_decoder_unit.sv */
// url_percent_decoder_unit: streaming URL percent decoder, one encoded byte
// per item in, decoded bytes out. Depends on upd_pkg.
//
// Path: an accepted item is held in the input register, its results go to
// the result register. Throughput: one item per cycle while out_stall is low.
// An item that yields two results (a percent sign followed by the string's
// final byte) holds the input register until both have gone out. An item
// that yields nothing frees its slot without output.
// Reset (arst_n low, asynchronous): both registers empty, escape phase idle,
// plus_as_space cleared.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [upd_pkg::APB_ADDR_W-1:0] paddr,
	input  wire [upd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [upd_pkg::APB_DATA_W-1:0] prdata,
	output logic                          pready,
	// encoded byte items
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [7:0]                     in_byte,
	input  wire                           in_last,
	// decoded byte items
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_last
);
	import upd_pkg::*;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic plus_as_space_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_as_space_q <= 1'b0;
		end else if (cfg_wr && paddr == REG_PLUS_AS_SPACE) begin
			plus_as_space_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_PLUS_AS_SPACE) begin
			prdata[0] = plus_as_space_q;
		end
	end

	// ---------------------------------------------------------------
	// Input register. second_s1 marks that the first of two results
	// for this item has already gone to the output register.
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       second_s1;

	// escape state, updated when the item in stage 1 retires
	phase_t                 phase_q;
	logic [NIBBLE_BITS-1:0] high_nibble_q;

	// result register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// ---------------------------------------------------------------
	// Decode: up to two results per item
	// ---------------------------------------------------------------
	logic [1:0]             n_res;
	logic [7:0]             r0_byte, r1_byte, plain;
	logic                   r0_last;
	phase_t                 phase_nx;
	logic [NIBBLE_BITS-1:0] nibble_nx;
	logic                   out_free, retire, emit;
	logic [NIBBLE_BITS-1:0] lo_nibble;

	always_comb begin
		plain     = (plus_as_space_q && byte_s1 == CH_PLUS) ? CH_SPACE : byte_s1;
		lo_nibble = hex_value(byte_s1);
		n_res     = 2'd0;
		r0_byte   = plain;
		r0_last   = last_s1;
		r1_byte   = plain;
		phase_nx  = PH_IDLE;
		nibble_nx = high_nibble_q;
		case (phase_q)
			PH_PCT: begin
				if (last_s1) begin
					// percent then final byte: literal percent, then plain byte
					n_res   = 2'd2;
					r0_byte = CH_PERCENT;
					r0_last = 1'b0;
				end else begin
					nibble_nx = lo_nibble;
					phase_nx  = PH_DIGIT;
				end
			end
			PH_DIGIT: begin
				n_res   = 2'd1;
				r0_byte = {high_nibble_q, lo_nibble};
			end
			default: begin
				if (byte_s1 == CH_PERCENT && !last_s1) begin
					phase_nx = PH_PCT;
				end else begin
					n_res = 2'd1;
				end
			end
		endcase
		if (last_s1) begin
			phase_nx = PH_IDLE;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && (n_res != 2'd0) && out_free;
	assign retire   = valid_s1 &&
		((n_res == 2'd0) || (out_free && (n_res == 2'd1 || second_s1)));
	assign in_stall = valid_s1 && !retire;

	// stage 1 control and escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			second_s1     <= 1'b0;
			phase_q       <= PH_IDLE;
			high_nibble_q <= '0;
		end else begin
			if (retire) begin
				phase_q       <= phase_nx;
				high_nibble_q <= nibble_nx;
				second_s1     <= 1'b0;
			end else if (emit) begin
				second_s1 <= 1'b1;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= second_s1 ? r1_byte : r0_byte;
			out_last_q <= second_s1 ? 1'b1 : r0_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire
